>>> hw/rtl/cached_cgrom_glyph_fetch_assert.svh
// ----------------------------------------------------------------------------
// cached_cgrom_glyph_fetch_assert
// assertion macros for the glyph fetch rtl
// ----------------------------------------------------------------------------
`ifndef CACHED_CGROM_GLYPH_FETCH_ASSERT_SVH
`define CACHED_CGROM_GLYPH_FETCH_ASSERT_SVH

// same-cycle implication
`define CCGF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glyph fetch check failed");

// next-cycle implication
`define CCGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glyph fetch check failed");

`endif

>>> hw/rtl/ccgf_pkg.sv
// ----------------------------------------------------------------------------
// ccgf_pkg
// shared types and constants of the cached glyph fetch block
// ----------------------------------------------------------------------------
package ccgf_pkg;

	// input word kinds
	localparam logic [1:0] K_REQ    = 2'd0;
	localparam logic [1:0] K_STAT   = 2'd1;
	localparam logic [1:0] K_WIN    = 2'd2;
	localparam logic [1:0] K_UNUSED = 2'd3;

	// result operations
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_STAT  = 2'd1;
	localparam logic [1:0] OP_WIN   = 2'd2;
	localparam logic [1:0] OP_FONT  = 2'd3;

	// ports and values
	localparam logic [7:0] PORT_STAT  = 8'h60;
	localparam logic [7:0] PORT_MODE  = 8'h68;
	localparam logic [7:0] PORT_A1    = 8'ha1;
	localparam logic [7:0] PORT_A3    = 8'ha3;
	localparam logic [7:0] PORT_A5    = 8'ha5;
	localparam logic [7:0] MODE_ON    = 8'h0b;
	localparam logic [7:0] MODE_OFF   = 8'h0a;
	localparam logic [7:0] A5_SPECIAL = 8'h20;
	localparam logic [7:0] ROW_HALF   = 8'h20;
	localparam logic [7:0] SPEC_LO_A  = 8'h29;
	localparam logic [7:0] SPEC_HI_A  = 8'h2f;
	localparam logic [7:0] SPEC_LO_B  = 8'h76;
	localparam logic [7:0] SPEC_HI_B  = 8'h7f;
	localparam int         VSYNC_BIT  = 5;

	typedef enum logic [2:0] {
		SQ_STATUS,
		SQ_SETUP,
		SQ_READ,
		SQ_SWITCH,
		SQ_FINISH,
		SQ_HIT
	} seq_t;

	typedef struct packed {
		logic       cap_code;
		logic       clr_buf;
		logic       buf_wr;
		logic [4:0] buf_pos;
		logic       tag_rd;
		logic       glyph_rd;
		logic       emit;
		seq_t       seq;
		logic [5:0] cnt;
		logic       last;
		logic [5:0] fetch;
		logic       glyph_wr;
		logic       cache_fill;
	} cmd_t;

	typedef struct packed {
		logic in_special;
		logic in_vsync;
		logic cur_special;
		logic cur_half;
		logic tag_match;
		logic out_free;
	} stat_t;

	function automatic logic is_special(input logic [15:0] c);
		return (c[15:8] >= SPEC_LO_A && c[15:8] <= SPEC_HI_A) ||
			(c[15:8] >= SPEC_LO_B && c[15:8] <= SPEC_HI_B);
	endfunction

endpackage

>>> hw/rtl/ccgf_if.sv
// ----------------------------------------------------------------------------
// ccgf channels
// valid/ready channels for requests and answers in, results out
// ----------------------------------------------------------------------------
interface ccgf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] code;
	logic [7:0]  bus_data;
	modport source (output valid, kind, code, bus_data, input ready);
	modport sink (input valid, kind, code, bus_data, output ready);
endinterface

interface ccgf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] port;
	logic [7:0] value;
	logic [4:0] window_offset;
	logic [4:0] font_index;
	logic       from_cache;
	logic       last;
	modport source (output valid, op, port, value, window_offset, font_index, from_cache,
		last, input ready);
	modport sink (input valid, op, port, value, window_offset, font_index, from_cache,
		last, output ready);
endinterface

>>> hw/rtl/ccgf_ctrl.sv
// ----------------------------------------------------------------------------
// ccgf_ctrl
// sequencer: fetch phase, cache scan, result sequences
// ----------------------------------------------------------------------------
module ccgf_ctrl #(
	parameter int N  = 64,
	parameter int IW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_kind,
	output logic            in_ready,
	input  ccgf_pkg::stat_t st,
	output ccgf_pkg::cmd_t  cmd,
	output logic [IW-1:0]   lk_rd_idx,
	output logic [IW-1:0]   lk_cmp_idx,
	output logic [IW-1:0]   hit_slot
);
	import ccgf_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_LOOKUP, ST_HIT_RD, ST_HIT_OUT, ST_EMIT} state_t;
	typedef enum logic [2:0] {PH_IDLE, PH_WAIT_LOW, PH_WAIT_HIGH, PH_READ, PH_READ2} phase_t;

	state_t        state_q;
	phase_t        phase_q;
	seq_t          seq_q;
	logic [5:0]    cnt_q;
	logic [5:0]    fetch_q;
	logic [IW:0]   lk_idx_q;
	logic          lk_vld_s1;
	logic [IW-1:0] lk_idx_s1;
	logic [IW-1:0] hit_q;

	logic       acc;
	logic [5:0] fetch_nx;
	logic [5:0] total;
	logic [5:0] seq_len;

	assign in_ready   = (state_q == ST_IDLE);
	assign acc        = in_valid && in_ready;
	assign fetch_nx   = fetch_q + 6'd1;
	assign total      = (st.cur_special || st.cur_half) ? 6'd16 : 6'd32;
	assign lk_rd_idx  = lk_idx_q[IW-1:0];
	assign lk_cmp_idx = lk_idx_s1;
	assign hit_slot   = hit_q;

	always_comb begin
		case (seq_q)
			SQ_SETUP:  seq_len = 6'd5;
			SQ_SWITCH: seq_len = 6'd2;
			SQ_FINISH: seq_len = 6'd33;
			SQ_HIT:    seq_len = 6'd32;
			default:   seq_len = 6'd1;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.seq      = seq_q;
		cmd.cnt      = cnt_q;
		cmd.fetch    = fetch_q;
		cmd.last     = (cnt_q == seq_len - 6'd1);
		cmd.cap_code = acc && in_kind == K_REQ && phase_q == PH_IDLE;
		cmd.clr_buf  = (acc && in_kind == K_REQ && phase_q == PH_IDLE && st.in_special) ||
			(state_q == ST_LOOKUP && lk_vld_s1 && !st.tag_match &&
			lk_idx_s1 == IW'(N - 1));
		if (acc && in_kind == K_WIN && (phase_q == PH_READ || phase_q == PH_READ2)) begin
			cmd.buf_wr = 1'b1;
			if (st.cur_special)
				cmd.buf_pos = {fetch_q[3:0], phase_q == PH_READ2};
			else if (st.cur_half)
				cmd.buf_pos = {1'b0, fetch_q[3:0]};
			else
				cmd.buf_pos = fetch_q[4:0];
		end
		cmd.tag_rd   = (state_q == ST_LOOKUP) && (lk_idx_q < (IW+1)'(N));
		cmd.glyph_rd = (state_q == ST_HIT_RD);
		if ((state_q == ST_EMIT || state_q == ST_HIT_OUT) && st.out_free) begin
			cmd.emit = 1'b1;
			if (seq_q == SQ_FINISH && !st.cur_special) begin
				cmd.glyph_wr   = (cnt_q != 6'd0);
				cmd.cache_fill = (cnt_q == 6'd32);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_IDLE;
			seq_q     <= SQ_STATUS;
			cnt_q     <= '0;
			fetch_q   <= '0;
			lk_idx_q  <= '0;
			lk_vld_s1 <= 1'b0;
			lk_idx_s1 <= '0;
			hit_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (acc) begin
						case (in_kind)
							K_REQ: begin
								if (phase_q == PH_IDLE) begin
									if (st.in_special) begin
										phase_q <= PH_WAIT_LOW;
										seq_q   <= SQ_STATUS;
										state_q <= ST_EMIT;
									end else begin
										lk_idx_q  <= '0;
										lk_vld_s1 <= 1'b0;
										state_q   <= ST_LOOKUP;
									end
								end
							end
							K_STAT: begin
								if (phase_q == PH_WAIT_LOW) begin
									if (!st.in_vsync)
										phase_q <= PH_WAIT_HIGH;
									seq_q   <= SQ_STATUS;
									state_q <= ST_EMIT;
								end else if (phase_q == PH_WAIT_HIGH) begin
									if (!st.in_vsync) begin
										seq_q <= SQ_STATUS;
									end else begin
										seq_q   <= SQ_SETUP;
										fetch_q <= '0;
										phase_q <= PH_READ;
									end
									state_q <= ST_EMIT;
								end
							end
							K_WIN: begin
								if (phase_q == PH_READ || phase_q == PH_READ2) begin
									state_q <= ST_EMIT;
									if (fetch_nx < total) begin
										fetch_q <= fetch_nx;
										seq_q   <= SQ_READ;
									end else if (st.cur_special && phase_q == PH_READ) begin
										fetch_q <= '0;
										phase_q <= PH_READ2;
										seq_q   <= SQ_SWITCH;
									end else begin
										fetch_q <= '0;
										phase_q <= PH_IDLE;
										seq_q   <= SQ_FINISH;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_LOOKUP: begin
					lk_vld_s1 <= cmd.tag_rd;
					lk_idx_s1 <= lk_idx_q[IW-1:0];
					if (cmd.tag_rd)
						lk_idx_q <= lk_idx_q + 1'b1;
					if (lk_vld_s1 && st.tag_match) begin
						hit_q   <= lk_idx_s1;
						seq_q   <= SQ_HIT;
						cnt_q   <= '0;
						state_q <= ST_HIT_RD;
					end else if (lk_vld_s1 && lk_idx_s1 == IW'(N - 1)) begin
						phase_q <= PH_WAIT_LOW;
						seq_q   <= SQ_STATUS;
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_HIT_RD: state_q <= ST_HIT_OUT;
				ST_HIT_OUT: begin
					if (cmd.emit) begin
						cnt_q   <= cnt_q + 6'd1;
						state_q <= cmd.last ? ST_IDLE : ST_HIT_RD;
					end
				end
				ST_EMIT: begin
					if (cmd.emit) begin
						cnt_q <= cnt_q + 6'd1;
						if (cmd.last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/ccgf_dpath.sv
// ----------------------------------------------------------------------------
// ccgf_dpath
// code register, assembly buffer, tag and glyph stores, result register
// ----------------------------------------------------------------------------
module ccgf_dpath #(
	parameter int N  = 64,
	parameter int IW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     in_code,
	input  logic [7:0]      in_bus_data,
	input  ccgf_pkg::cmd_t  cmd,
	input  logic [IW-1:0]   lk_rd_idx,
	input  logic [IW-1:0]   lk_cmp_idx,
	input  logic [IW-1:0]   hit_slot,
	output ccgf_pkg::stat_t st,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      out_op,
	output logic [7:0]      out_port,
	output logic [7:0]      out_value,
	output logic [4:0]      out_window_offset,
	output logic [4:0]      out_font_index,
	output logic            out_from_cache,
	output logic            out_last
);
	import ccgf_pkg::*;

	logic [15:0]   code_q;
	logic [7:0]    buf_q [32];
	logic [15:0]   tag_mem [N];
	logic [7:0]    glyph_mem [N*32];
	logic [N-1:0]  valid_q;
	logic [IW-1:0] rp_q;
	logic [15:0]   tag_rd_s1;
	logic [7:0]    glyph_rd_s1;

	logic          ov_q;
	logic [1:0]    op_q;
	logic [7:0]    port_q;
	logic [7:0]    value_q;
	logic [4:0]    woff_q;
	logic [4:0]    fidx_q;
	logic          fc_q;
	logic          last_q;

	logic [1:0]    op_d;
	logic [7:0]    port_d;
	logic [7:0]    value_d;
	logic [4:0]    woff_d;
	logic [4:0]    fidx_d;
	logic          fc_d;
	logic [4:0]    rd_off;
	logic [4:0]    byte_idx;
	logic [7:0]    row_off;

	assign st.in_special  = is_special(in_code);
	assign st.in_vsync    = in_bus_data[VSYNC_BIT];
	assign st.cur_special = is_special(code_q);
	assign st.cur_half    = (code_q[15:8] == ROW_HALF);
	assign st.tag_match   = valid_q[lk_cmp_idx] && (tag_rd_s1 == code_q);
	assign st.out_free    = !ov_q || out_ready;

	assign rd_off   = (st.cur_half || st.cur_special) ? {cmd.fetch[3:0], 1'b1} : cmd.fetch[4:0];
	assign byte_idx = 5'(cmd.cnt - 6'd1);
	assign row_off  = code_q[15:8] - ROW_HALF;

	// payload of the next result word
	always_comb begin
		op_d    = OP_WRITE;
		port_d  = '0;
		value_d = '0;
		woff_d  = '0;
		fidx_d  = '0;
		fc_d    = 1'b0;
		case (cmd.seq)
			SQ_STATUS: begin
				op_d   = OP_STAT;
				port_d = PORT_STAT;
			end
			SQ_SETUP: begin
				case (cmd.cnt)
					6'd0: begin
						port_d  = PORT_MODE;
						value_d = MODE_ON;
					end
					6'd1: begin
						port_d  = PORT_A1;
						value_d = st.cur_half ? 8'h00 : code_q[7:0];
					end
					6'd2: begin
						port_d  = PORT_A3;
						value_d = st.cur_half ? code_q[7:0] : row_off;
					end
					6'd3: begin
						port_d  = PORT_A5;
						value_d = st.cur_special ? A5_SPECIAL : 8'h00;
					end
					default: begin
						op_d   = OP_WIN;
						woff_d = rd_off;
					end
				endcase
			end
			SQ_READ: begin
				op_d   = OP_WIN;
				woff_d = rd_off;
			end
			SQ_SWITCH: begin
				if (cmd.cnt == 6'd0) begin
					port_d = PORT_A5;
				end else begin
					op_d   = OP_WIN;
					woff_d = rd_off;
				end
			end
			SQ_FINISH: begin
				if (cmd.cnt == 6'd0) begin
					port_d  = PORT_MODE;
					value_d = MODE_OFF;
				end else begin
					op_d    = OP_FONT;
					value_d = buf_q[byte_idx];
					fidx_d  = byte_idx;
				end
			end
			SQ_HIT: begin
				op_d    = OP_FONT;
				value_d = glyph_rd_s1;
				fidx_d  = cmd.cnt[4:0];
				fc_d    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			valid_q <= '0;
			rp_q    <= '0;
		end else begin
			if (cmd.emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			if (cmd.cache_fill) begin
				valid_q[rp_q] <= 1'b1;
				rp_q <= (rp_q == IW'(N - 1)) ? '0 : rp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_code)
			code_q <= in_code;
		if (cmd.clr_buf) begin
			for (int i = 0; i < 32; i++)
				buf_q[i] <= '0;
		end else if (cmd.buf_wr) begin
			buf_q[cmd.buf_pos] <= in_bus_data;
		end
		if (cmd.emit) begin
			op_q    <= op_d;
			port_q  <= port_d;
			value_q <= value_d;
			woff_q  <= woff_d;
			fidx_q  <= fidx_d;
			fc_q    <= fc_d;
			last_q  <= cmd.last;
		end
	end

	// tag store
	always_ff @(posedge clk) begin
		if (cmd.cache_fill)
			tag_mem[rp_q] <= code_q;
		if (cmd.tag_rd)
			tag_rd_s1 <= tag_mem[lk_rd_idx];
	end

	// glyph store
	always_ff @(posedge clk) begin
		if (cmd.glyph_wr)
			glyph_mem[{rp_q, byte_idx}] <= buf_q[byte_idx];
		if (cmd.glyph_rd)
			glyph_rd_s1 <= glyph_mem[{hit_slot, cmd.cnt[4:0]}];
	end

	assign out_valid         = ov_q;
	assign out_op            = op_q;
	assign out_port          = port_q;
	assign out_value         = value_q;
	assign out_window_offset = woff_q;
	assign out_font_index    = fidx_q;
	assign out_from_cache    = fc_q;
	assign out_last          = last_q;
endmodule

>>> hw/rtl/cached_cgrom_glyph_fetch.sv
// ----------------------------------------------------------------------------
// cached_cgrom_glyph_fetch
// glyph fetch from the character rom with a round-robin glyph cache
//
//   channel  dir  words                                  accepted when
//   in_ch    in   glyph request, status / window answer  valid && ready
//   out_ch   out  bus operation or font byte             valid && ready
//
// one input word is handled at a time; ready stays low until its last result
// word has been loaded into the output register.
// a cache hit costs a scan over the tag memory port, then for each font byte a glyph
// memory read followed by loading that byte into the output register.
// a miss result sequence runs at one word per cycle while the output is free (33 words at the end).
// reset clears the valid bits, replace pointer and fetch phase at once.
// a stalled output simply holds the sequencer; nothing is dropped.
// ----------------------------------------------------------------------------
`include "cached_cgrom_glyph_fetch_assert.svh"

module cached_cgrom_glyph_fetch #(
	parameter int CACHE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ccgf_in_if.sink     in_ch,
	ccgf_out_if.source  out_ch
);
	import ccgf_pkg::*;

	// index width of one cache slot
	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	cmd_t          cmd;
	stat_t         st;
	logic [IW-1:0] lk_rd_idx;
	logic [IW-1:0] lk_cmp_idx;
	logic [IW-1:0] hit_slot;
	logic          in_rdy;

	assign in_ch.ready = in_rdy;

	// sequencer
	ccgf_ctrl #(.N(CACHE_ENTRIES), .IW(IW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_kind    (in_ch.kind),
		.in_ready   (in_rdy),
		.st         (st),
		.cmd        (cmd),
		.lk_rd_idx  (lk_rd_idx),
		.lk_cmp_idx (lk_cmp_idx),
		.hit_slot   (hit_slot)
	);

	// stores and result register
	ccgf_dpath #(.N(CACHE_ENTRIES), .IW(IW)) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_code           (in_ch.code),
		.in_bus_data       (in_ch.bus_data),
		.cmd               (cmd),
		.lk_rd_idx         (lk_rd_idx),
		.lk_cmp_idx        (lk_cmp_idx),
		.hit_slot          (hit_slot),
		.st                (st),
		.out_valid         (out_ch.valid),
		.out_ready         (out_ch.ready),
		.out_op            (out_ch.op),
		.out_port          (out_ch.port),
		.out_value         (out_ch.value),
		.out_window_offset (out_ch.window_offset),
		.out_font_index    (out_ch.font_index),
		.out_from_cache    (out_ch.from_cache),
		.out_last          (out_ch.last)
	);

	// no result word is produced while a new input word may be taken
	`CCGF_ASSERT_NOW(a_idle_no_emit, clk, arst_n, in_rdy, !cmd.emit)
	// the sequencer returns to accepting input right after the last word
	`CCGF_ASSERT_NEXT(a_last_frees, clk, arst_n, cmd.emit && cmd.last, in_rdy)
	// the cache scan never overlaps an accepted input word
	`CCGF_ASSERT_NOW(a_scan_busy, clk, arst_n, cmd.tag_rd, !in_rdy)
endmodule
